>>> rtl/tx_slot_block_allocator_unit_defines.svh
// Assertion macros for the transmit slot and block allocator.
// Used by tx_slot_block_allocator_unit.sv; the macros expect clk_i and rst_ni in scope.
`ifndef TX_SLOT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define TX_SLOT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, off while in reset
`define TSBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define TSBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TSBA_ASSERT_IMP(label, ante, cons, msg)
`define TSBA_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/tsba_pkg.sv
// Types and constants for the transmit slot and block allocator.
// No dependencies; imported by tx_slot_block_allocator_unit.
`default_nettype none

package tsba_pkg;

  // Sizing
  localparam int SLOT_COUNT   = 16;
  localparam int BLOCK_SHIFT  = 8;
  localparam int SPARE_BLOCKS = 2;
  localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Field widths
  localparam int FRAME_LEN_W = 12;
  localparam int ID_W        = 8;
  localparam int STATUS_W    = 8;
  localparam int FAIL_W      = 8;
  localparam int FREED_W     = 10;
  localparam int SLOT_ID_W   = 4;
  localparam int TAKEN_W     = 5;
  localparam int BLOCKS_W    = 16;
  localparam int COUNT_W     = 32;
  localparam int NEED_W      = 16;

  // Block count arithmetic constants
  localparam logic [FRAME_LEN_W-1:0] EXCL_MASK  = FRAME_LEN_W'(8'hff);
  localparam logic [NEED_W-1:0]      EXCL_PAD   = NEED_W'(34);
  localparam logic [NEED_W-1:0]      EXCL_LIMIT = NEED_W'(252);
  localparam logic [NEED_W-1:0]      TAKEN_MAX  = NEED_W'((1 << TAKEN_W) - 1);
  localparam logic [STATUS_W-1:0]    RETRY_MASK_RST = STATUS_W'(3);

  typedef enum logic [1:0] {
    FUNC_ALLOC    = 2'd0,
    FUNC_COMPLETE = 2'd1,
    FUNC_CREDIT   = 2'd2,
    FUNC_NONE     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    RES_OK         = 2'd0,
    RES_BUSY       = 2'd1,
    RES_ILLEGAL_ID = 2'd2
  } result_e;

  typedef struct packed {
    func_e                  func;
    logic [FRAME_LEN_W-1:0] frame_len;
    logic [ID_W-1:0]        result_id;
    logic [STATUS_W-1:0]    result_status;
    logic [FAIL_W-1:0]      fail_count;
    logic                   no_ack;
    logic [FREED_W-1:0]     freed_blocks;
  } alloc_req_t;

  typedef struct packed {
    result_e              result_code;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [TAKEN_W-1:0]   blocks_taken;
    logic [BLOCKS_W-1:0]  blocks_left;
    logic                 acked;
    logic [COUNT_W-1:0]   retry_limit_hits;
    logic [COUNT_W-1:0]   failure_total;
  } alloc_rsp_t;

endpackage

`default_nettype wire

>>> rtl/tx_slot_block_allocator_unit.sv
// Registers: input register, then result register; all logic lies between the two.
// Throughput: one beat per cycle unless the result channel stalls; the slot search is
// a priority encoder over the busy flags, the block count two shifts and four adds.
// Reset: asynchronous, active low; all slots free, zero free blocks, counters cleared,
// retry mask back to 3. No clearing pass; items are taken right after reset.
`default_nettype none

`include "tx_slot_block_allocator_unit_defines.svh"

module tx_slot_block_allocator_unit
  import tsba_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // Configuration: retry exceeded mask
  input  wire logic          cfg_we_i,
  input  wire logic [STATUS_W-1:0] cfg_wdata_i,
  // Request channel
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire alloc_req_t    in_data_i,
  // Result channel
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output alloc_rsp_t         out_data_o
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic                  in_valid_q;
  alloc_req_t            in_q;
  logic                  out_valid_q;
  alloc_rsp_t            out_q, out_d;

  logic [SLOT_COUNT-1:0] slot_busy_q, slot_busy_d;
  logic [BLOCKS_W-1:0]   blocks_free_q, blocks_free_d;
  logic [COUNT_W-1:0]    retry_hits_q, retry_hits_d;
  logic [COUNT_W-1:0]    failure_sum_q, failure_sum_d;
  logic [STATUS_W-1:0]   retry_mask_q;

  // Handshake: the held beat moves into the result register whenever that
  // register is empty or being drained this cycle.
  logic in_accept;
  logic advance;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Lowest free slot: priority encoder over the busy flags
  // ---------------------------------------------------------------------------
  logic              found;
  logic [SLOT_W-1:0] free_idx;

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_busy_q[i]) begin
        found    = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Blocks needed by the frame: length in blocks, plus one or two depending on
  // whether the tail plus header overhead spills over, plus the spare blocks.
  // ---------------------------------------------------------------------------
  logic [NEED_W-1:0] len_blocks;
  logic [NEED_W-1:0] excl;
  logic [NEED_W-1:0] need;

  always_comb begin
    len_blocks = NEED_W'(in_q.frame_len >> BLOCK_SHIFT);
    excl       = (len_blocks << 2) + NEED_W'(in_q.frame_len & EXCL_MASK) + EXCL_PAD;
    need       = len_blocks + ((excl > EXCL_LIMIT) ? NEED_W'(2) : NEED_W'(1))
               + NEED_W'(SPARE_BLOCKS);
  end

  // ---------------------------------------------------------------------------
  // Completion slot check and credit saturation
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0]   id_idx;
  logic                id_ok;
  logic [BLOCKS_W:0]   credit_sum;
  logic                grant;

  assign id_idx     = in_q.result_id[SLOT_W-1:0];
  assign id_ok      = (in_q.result_id < ID_W'(SLOT_COUNT)) && slot_busy_q[id_idx];
  assign credit_sum = {1'b0, blocks_free_q} + (BLOCKS_W + 1)'(in_q.freed_blocks);
  assign grant      = (in_q.func == FUNC_ALLOC) && found && (need <= NEED_W'(blocks_free_q));

  // ---------------------------------------------------------------------------
  // Item processing: next state and the result beat
  // ---------------------------------------------------------------------------
  always_comb begin
    slot_busy_d   = slot_busy_q;
    blocks_free_d = blocks_free_q;
    retry_hits_d  = retry_hits_q;
    failure_sum_d = failure_sum_q;

    out_d              = '0;
    out_d.result_code  = RES_OK;

    case (in_q.func)
      FUNC_ALLOC: begin
        if (!found) begin
          out_d.result_code = RES_BUSY;
        end else begin
          out_d.blocks_taken = (need > TAKEN_MAX) ? TAKEN_W'(TAKEN_MAX) : need[TAKEN_W-1:0];
          if (grant) begin
            slot_busy_d[free_idx] = 1'b1;
            blocks_free_d         = blocks_free_q - BLOCKS_W'(need);
            out_d.slot_id         = SLOT_ID_W'({{SLOT_ID_W{1'b0}}, free_idx});
          end else begin
            // Not enough blocks: the slot stays free
            out_d.result_code = RES_BUSY;
          end
        end
      end
      FUNC_COMPLETE: begin
        if (!id_ok) begin
          out_d.result_code = RES_ILLEGAL_ID;
        end else begin
          if (!in_q.no_ack) begin
            out_d.acked = (in_q.result_status == '0);
            if ((in_q.result_status & retry_mask_q) != '0) begin
              retry_hits_d = retry_hits_q + COUNT_W'(1);
            end
          end
          failure_sum_d       = failure_sum_q + COUNT_W'(in_q.fail_count);
          slot_busy_d[id_idx] = 1'b0;
          out_d.slot_id       = SLOT_ID_W'({{SLOT_ID_W{1'b0}}, id_idx});
        end
      end
      FUNC_CREDIT: begin
        // Saturate the free block count
        blocks_free_d = credit_sum[BLOCKS_W] ? '1 : credit_sum[BLOCKS_W-1:0];
      end
      default: begin
        // Unused function: report state only
      end
    endcase

    out_d.blocks_left      = blocks_free_d;
    out_d.retry_limit_hits = retry_hits_d;
    out_d.failure_total    = failure_sum_d;
  end

  // ---------------------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      slot_busy_q   <= '0;
      blocks_free_q <= '0;
      retry_hits_q  <= '0;
      failure_sum_q <= '0;
      retry_mask_q  <= RETRY_MASK_RST;
    end else begin
      // Hold the input beat until it advances
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      // Drop the result beat once taken, unless a new one replaces it
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (advance) begin
        slot_busy_q   <= slot_busy_d;
        blocks_free_q <= blocks_free_d;
        retry_hits_q  <= retry_hits_d;
        failure_sum_q <= failure_sum_d;
      end

      if (cfg_we_i) begin
        retry_mask_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TSBA_ASSERT_NXT(a_grant_marks_busy, advance && grant, slot_busy_q[$past(free_idx)], "granted slot not marked busy")
  `TSBA_ASSERT_NXT(a_free_only_grows_on_credit, !(advance && (in_q.func == FUNC_CREDIT)), blocks_free_q <= $past(blocks_free_q), "free blocks grew without credit")
  `TSBA_ASSERT_IMP(a_refused_has_no_slot, out_valid_q && (out_q.result_code != RES_OK), (out_q.slot_id == '0) && !out_q.acked, "refused result carries slot or ack")
  `TSBA_ASSERT_NXT(a_held_beat_kept, in_valid_q && !advance, in_valid_q, "held input beat lost")

endmodule

`default_nettype wire
